@@ hw/rtl/pat_pkg.sv @@
package pat_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int GROUP   = 8;
    localparam int NGROUP  = DEPTH / GROUP;
    localparam int GIDX_W  = $clog2(GROUP);

    typedef logic signed [31:0] word_t;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADPOS   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic [1:0] ACT_HOLD  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_LEFT  = 2'd2;
    localparam logic [1:0] ACT_RIGHT = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  position;
        word_t       value;
    } pat_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  found_index;
        word_t       read_word;
        logic [6:0]  entry_count;
    } pat_out_t;

    typedef struct packed {
        logic [1:0]  act;
        logic        probe;
        logic        match_en;
    } pat_cell_cmd_t;

endpackage

@@ hw/rtl/pat_cell.sv @@
module pat_cell
    import pat_pkg::*;
(
    input  logic          clk,
    input  pat_cell_cmd_t cmd,
    input  word_t         key,
    input  word_t         left_word,
    input  word_t         right_word,
    output word_t         word,
    output logic          hit
);

    word_t word_reg;
    word_t word_next;
    logic  hit_reg;
    logic  hit_next;

    always_comb
    begin
        case (cmd.act)
            ACT_LOAD:  word_next = key;
            ACT_LEFT:  word_next = left_word;
            ACT_RIGHT: word_next = right_word;
            default:   word_next = word_reg;
        endcase
        hit_next = cmd.probe && (!cmd.match_en || (word_reg == key));
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        hit_reg  <= hit_next;
    end

    assign word = word_reg;
    assign hit  = hit_reg;

endmodule

@@ hw/rtl/pat_group.sv @@
module pat_group
    import pat_pkg::*;
(
    input  logic                   clk,
    input  logic [GROUP-1:0]       hits,
    input  word_t [GROUP-1:0]      words,
    output logic                   any,
    output logic [GIDX_W-1:0]      idx,
    output word_t                  word
);

    logic              any_reg;
    logic              any_next;
    logic [GIDX_W-1:0] idx_reg;
    logic [GIDX_W-1:0] idx_next;
    word_t             word_reg;
    word_t             word_next;

    // lowest hit wins
    always_comb
    begin
        any_next  = 1'b0;
        idx_next  = '0;
        word_next = '0;
        for (int i = GROUP - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                any_next  = 1'b1;
                idx_next  = GIDX_W'(i);
                word_next = words[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        any_reg  <= any_next;
        idx_reg  <= idx_next;
        word_reg <= word_next;
    end

    assign any  = any_reg;
    assign idx  = idx_reg;
    assign word = word_reg;

endmodule

@@ hw/rtl/positional_array_table.sv @@
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-----------------------------------
// cmd       | in        | cmd_valid, cmd_ready | operation, position, value
// res       | out       | res_valid, res_ready | status, found_index, read_word,
//           |           |                      | entry_count
//
// one item at a time: after the accept, insert and delete pass through S_EXEC and
// S_WAIT, and search and read through S_EXEC, S_GROUP and S_WAIT, set by the cell
// row update and the two-level registered match tree (cells, then groups of eight);
// res_valid rises as S_WAIT ends, and cmd_ready returns with the result.
// a finished item sits in the output register; the next item is accepted
// meanwhile, and its result waits in its final step while res_ready is low.
// reset clears the count and the control; entries are not cleared.
module positional_array_table
    import pat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  pat_in_t  cmd,
    output logic     res_valid,
    input  logic     res_ready,
    output pat_out_t res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_GROUP = 2'd2;
    localparam logic [1:0] S_WAIT  = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [1:0]       op_reg;
    logic [6:0]       pos_reg;
    word_t            val_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [2:0]       status_reg;
    logic [2:0]       status_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    pat_out_t         res_reg;
    pat_out_t         res_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             ins_ok;
    logic             del_ok;
    logic             load_out;

    pat_cell_cmd_t [DEPTH-1:0]  cell_cmd;
    word_t [DEPTH-1:0]          cell_word;
    logic [DEPTH-1:0]           cell_hit;
    logic [NGROUP-1:0]          grp_any;
    logic [NGROUP-1:0][GIDX_W-1:0] grp_idx;
    word_t [NGROUP-1:0]         grp_word;

    logic             sel_any;
    logic [IDX_W-1:0] sel_idx;
    word_t            sel_word;

    assign accept    = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == S_IDLE);

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign ins_ok = !full && (pos_reg <= 7'(count_reg));
    assign del_ok = !empty && (pos_reg < 7'(count_reg));

    // per-cell commands; probes follow the held item so the hit bits stay put
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cmd
        always_comb
        begin
            cell_cmd[i].act = ACT_HOLD;
            if (state_reg == S_EXEC)
            begin
                if (op_reg == OP_INSERT && ins_ok)
                begin
                    if (pos_reg == 7'(i))
                        cell_cmd[i].act = ACT_LOAD;
                    else if (pos_reg < 7'(i))
                        cell_cmd[i].act = ACT_LEFT;
                end
                else if (op_reg == OP_DELETE && del_ok && pos_reg <= 7'(i))
                begin
                    cell_cmd[i].act = ACT_RIGHT;
                end
            end
            cell_cmd[i].match_en = (op_reg == OP_SEARCH);
            if (op_reg == OP_SEARCH)
                cell_cmd[i].probe = (CNT_W'(i) < count_reg);
            else
                cell_cmd[i].probe = (op_reg == OP_READ) && (pos_reg == 7'(i));
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t left_w;
        word_t right_w;
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_word[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = cell_word[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_word[i+1];
        end

        pat_cell u_cell (
            .clk        (clk),
            .cmd        (cell_cmd[i]),
            .key        (val_reg),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i]),
            .hit        (cell_hit[i])
        );
    end

    for (genvar g = 0; g < NGROUP; g++)
    begin : g_grp
        pat_group u_group (
            .clk   (clk),
            .hits  (cell_hit[g*GROUP +: GROUP]),
            .words (cell_word[g*GROUP +: GROUP]),
            .any   (grp_any[g]),
            .idx   (grp_idx[g]),
            .word  (grp_word[g])
        );
    end

    // lowest group with a hit
    always_comb
    begin
        sel_any  = 1'b0;
        sel_idx  = '0;
        sel_word = '0;
        for (int g = NGROUP - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                sel_any  = 1'b1;
                sel_idx  = IDX_W'(g * GROUP) | IDX_W'(grp_idx[g]);
                sel_word = grp_word[g];
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        load_out    = 1'b0;
        res_next    = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (full)
                            status_next = ST_FULL;
                        else if (!ins_ok)
                            status_next = ST_BADPOS;
                        else
                        begin
                            status_next = ST_OK;
                            count_next  = count_reg + CNT_W'(1);
                        end
                        state_next = S_WAIT;
                    end
                    OP_DELETE:
                    begin
                        if (empty)
                            status_next = ST_EMPTY;
                        else if (!del_ok)
                            status_next = ST_BADPOS;
                        else
                        begin
                            status_next = ST_OK;
                            count_next  = count_reg - CNT_W'(1);
                        end
                        state_next = S_WAIT;
                    end
                    OP_READ:
                    begin
                        if (empty)
                            status_next = ST_EMPTY;
                        else if (!del_ok)
                            status_next = ST_BADPOS;
                        else
                            status_next = ST_OK;
                        state_next = S_GROUP;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                        state_next  = S_GROUP;
                    end
                endcase
            end
            S_GROUP:
            begin
                state_next = S_WAIT;
            end
            default:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    load_out             = 1'b1;
                    state_next           = S_IDLE;
                    res_next.entry_count = 7'(count_reg);
                    res_next.found_index = '0;
                    res_next.read_word   = '0;
                    res_next.status      = status_reg;
                    if (op_reg == OP_SEARCH)
                    begin
                        if (sel_any)
                        begin
                            res_next.status      = ST_OK;
                            res_next.found_index = 6'(sel_idx);
                        end
                        else
                            res_next.status = ST_NOTFOUND;
                    end
                    else if (op_reg == OP_READ && status_reg == ST_OK)
                    begin
                        res_next.read_word = sel_word;
                    end
                end
            end
        endcase

        if (load_out)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= cmd.operation;
            pos_reg <= cmd.position;
            val_reg <= cmd.value;
        end
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
